FILE: src/lat_pkg.sv
// ----------------------------------------------------------------------------
// lat_pkg: shared definitions for the LRU address tracker
// Field widths, operation codes, register map, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

  localparam int ADDR_W    = 64;
  localparam int OCC_W     = 7;
  localparam int OP_W      = 2;
  localparam int CAP_W     = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // APB register map: one 32-bit register per word
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;
  localparam int REG_IDX_W = CFG_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY_LIMIT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_PURGE  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: src/lat_if.sv
// ----------------------------------------------------------------------------
// lat_if: valid/ready channels of the LRU address tracker
// Request channel (operation, address, range end) and result channel
// (eviction report, hit flag, occupancy).
// ----------------------------------------------------------------------------
`default_nettype none

interface lat_in_if import lat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] range_end;

  modport source (output valid, operation, address, range_end, input ready);
  modport sink   (input valid, operation, address, range_end, output ready);
endinterface

interface lat_out_if import lat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              evicted_valid;
  logic [ADDR_W-1:0] evicted_address;
  logic              hit;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, evicted_valid, evicted_address, hit, occupancy,
                  input ready);
  modport sink   (input valid, evicted_valid, evicted_address, hit, occupancy,
                  output ready);
endinterface

`default_nettype wire

FILE: src/lat_ctrl.sv
// ----------------------------------------------------------------------------
// lat_ctrl: sequencing controller
// Takes one transaction at a time, runs the list scan in the datapath for all
// but clear and commits the result once the output register can take it.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_ctrl import lat_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_op,
  output logic            in_ready,
  output ctrl_cmd_t       cmd,
  input  dp_sts_t         sts
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // clear needs no pass over the list
          state_nxt = (op_t'(in_op) == OP_CLEAR) ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/lat_datapath.sv
// ----------------------------------------------------------------------------
// lat_datapath: recency list storage and scan datapath
// Circular slot memory (oldest at head), one-entry-per-cycle compare scan
// that compacts in place for touch/purge, commit logic and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_datapath import lat_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_cmd_t         cmd,
  output dp_sts_t           sts,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [ADDR_W-1:0] in_range_end,
  input  logic [CAP_W-1:0]  cap_limit,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_evicted_valid,
  output logic [ADDR_W-1:0] out_evicted_address,
  output logic              out_hit,
  output logic [OCC_W-1:0]  out_occupancy
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] p);
    next_slot = (p == LAST_SLOT) ? '0 : p + IW'(1);
  endfunction

  logic [ADDR_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  op_t               op_r;
  logic [ADDR_W-1:0] addr_r, end_r, oldest_r;
  logic [IW-1:0]     head_r, head_nxt, rd_ptr_r, wr_ptr_r;
  logic [CW-1:0]     count_r, count_nxt, issued_r, seen_r, kept_r;
  logic              rd_pend_r, hit_r;

  logic              out_valid_r, ev_valid_r, hit_out_r;
  logic [ADDR_W-1:0] ev_addr_r;
  logic [OCC_W-1:0]  occ_r;

  logic              rd_en, match, in_range, drop, compact, at_limit;
  logic              c_we, c_ev_valid, c_hit;
  logic [ADDR_W-1:0] c_ev_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wdata;
  logic [LW-1:0]     cap_w, depth_w, limit_w, cnt_w;

  assign rd_en    = cmd.scan && (issued_r != count_r);
  assign match    = (rdata_r == addr_r);
  assign in_range = (rdata_r >= addr_r) && (rdata_r < end_r);
  assign compact  = (op_r == OP_TOUCH) || (op_r == OP_PURGE);

  always_comb begin
    case (op_r)
      OP_TOUCH: drop = match;
      OP_PURGE: drop = in_range;
      default:  drop = 1'b0;
    endcase
  end

  // effective limit is the register clamped to the slot count
  always_comb begin
    cap_w    = LW'(cap_limit);
    depth_w  = LW'(DEPTH);
    cnt_w    = LW'(count_r);
    limit_w  = (cap_w > depth_w) ? depth_w : cap_w;
    at_limit = (cnt_w >= limit_w);
  end

  // wr_ptr_r ends the scan at head + kept, the slot after the last survivor
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    c_we       = 1'b0;
    c_ev_valid = 1'b0;
    c_ev_addr  = '0;
    c_hit      = 1'b0;
    case (op_r)
      OP_TOUCH: begin
        if (hit_r) begin
          c_hit = 1'b1;
          c_we  = 1'b1;
        end else if (at_limit) begin
          c_ev_valid = 1'b1;
          if (count_r == '0) begin
            c_ev_addr = addr_r;
          end else begin
            // drop the oldest by advancing head; new entry lands after the last kept entry
            c_ev_addr = oldest_r;
            c_we      = 1'b1;
            head_nxt  = next_slot(head_r);
          end
        end else begin
          c_we      = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_LOOKUP: c_hit = hit_r;
      OP_PURGE:  count_nxt = kept_r;
      OP_CLEAR:  count_nxt = '0;
      default:   count_nxt = count_r;
    endcase
  end

  assign mem_we    = cmd.commit ? c_we : (rd_pend_r && !drop && compact);
  assign mem_wdata = cmd.commit ? addr_r : rdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_ptr_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[rd_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      issued_r    <= '0;
      seen_r      <= '0;
      kept_r      <= '0;
      rd_pend_r   <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      if (cmd.load) begin
        rd_ptr_r  <= head_r;
        wr_ptr_r  <= head_r;
        issued_r  <= '0;
        seen_r    <= '0;
        kept_r    <= '0;
        hit_r     <= 1'b0;
      end else begin
        if (rd_en) begin
          rd_ptr_r <= next_slot(rd_ptr_r);
          issued_r <= issued_r + CW'(1);
        end
        if (rd_pend_r) begin
          seen_r <= seen_r + CW'(1);
          if (match) begin
            hit_r <= 1'b1;
          end
          if (!drop) begin
            wr_ptr_r <= next_slot(wr_ptr_r);
            kept_r   <= kept_r + CW'(1);
          end
        end
      end
      if (cmd.commit) begin
        head_r      <= head_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_operation);
      addr_r <= in_address;
      end_r  <= in_range_end;
    end
    // capture the oldest entry as it streams past
    if (rd_pend_r && (seen_r == '0)) begin
      oldest_r <= rdata_r;
    end
    if (cmd.commit) begin
      ev_valid_r <= c_ev_valid;
      ev_addr_r  <= c_ev_addr;
      hit_out_r  <= c_hit;
      occ_r      <= OCC_W'(count_nxt);
    end
  end

  assign sts.scan_done = (seen_r == count_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid           = out_valid_r;
  assign out_evicted_valid   = ev_valid_r;
  assign out_evicted_address = ev_addr_r;
  assign out_hit             = hit_out_r;
  assign out_occupancy       = occ_r;

endmodule

`default_nettype wire

FILE: src/lru_address_tracker.sv
// ----------------------------------------------------------------------------
// lru_address_tracker: recency-ordered address list with LRU eviction
// Keeps up to DEPTH 64-bit addresses, oldest first, in a single-port-read
// slot memory used as a circular list. Touch, lookup and purge each walk the
// held entries one per cycle through the memory read port, comparing and,
// for touch and purge, compacting in place; clear skips the walk. The commit
// is held while the previous result still waits on the output. One
// transaction is in flight at a time; its result sits in an output register,
// so the next request is taken while the previous result waits.
// capacity_limit sits at APB word 0 (reset 64, clamped to DEPTH). No clearing
// pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_address_tracker import lat_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  lat_in_if.sink            in_ch,
  lat_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  ctrl_cmd_t               cmd;
  dp_sts_t                 sts;
  logic [CAP_W-1:0]        cap_r;
  logic [REG_IDX_W-1:0]    reg_idx;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY_LIMIT)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  assign prdata = (reg_idx == REG_CAPACITY_LIMIT) ? CFG_DW'(cap_r) : '0;

  lat_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  lat_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_operation        (in_ch.operation),
    .in_address          (in_ch.address),
    .in_range_end        (in_ch.range_end),
    .cap_limit           (cap_r),
    .out_ready           (out_ch.ready),
    .out_valid           (out_ch.valid),
    .out_evicted_valid   (out_ch.evicted_valid),
    .out_evicted_address (out_ch.evicted_address),
    .out_hit             (out_ch.hit),
    .out_occupancy       (out_ch.occupancy)
  );

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.out_free)
    else $error("result committed while output register still full");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("committed result not presented on output");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while a transaction is in progress");

endmodule

`default_nettype wire
